// ----- src/presence_event_window_filter_assert.svh -----
// Assertion macros used by the filter's back module.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef PRESENCE_EVENT_WINDOW_FILTER_ASSERT_SVH
`define PRESENCE_EVENT_WINDOW_FILTER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PEWF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define PEWF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define PEWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pewf_pkg.sv -----
`default_nettype none

package pewf_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W      = 4;
  localparam int ID_W       = 3;
  localparam int THR_W      = 12;
  localparam int WIN_REG_W  = 6;
  localparam int INTV_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int ENTRY_W    = ID_W + CNT_W;

  // Q4.8 fixed point: one unit is 256.
  localparam int Q48_SHIFT = 8;

  localparam logic [ID_W-1:0] ID_UNKNOWN    = 3'd0;
  localparam logic [ID_W-1:0] ID_LAST_KNOWN = 3'd5;

  localparam logic [INTV_W-1:0] INTV_MAX = 8'hFF;

  // Depth of the command queue between front and back (power of two).
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNOWN_FACE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_INTERVAL  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [WIN_REG_W-1:0] RST_WINDOW_SIZE     = 6'd10;
  localparam logic [THR_W-1:0]     RST_LOWER_THRESHOLD = 12'd128;
  localparam logic [THR_W-1:0]     RST_UPPER_THRESHOLD = 12'd384;
  localparam logic [THR_W-1:0]     RST_KNOWN_FACE_GAIN = 12'd256;
  localparam logic [INTV_W-1:0]    RST_EVENT_INTERVAL  = 8'd30;

  // Event kinds.
  localparam logic EV_ENTERED = 1'b0;
  localparam logic EV_LEFT    = 1'b1;

  // One classified observation handed from front to back.
  typedef struct packed {
    logic            decide;
    logic [ID_W-1:0]  face_id;
    logic [CNT_W-1:0] face_count;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] face;
    logic            last;
  } ev_t;

endpackage

`default_nettype wire

// ----- src/pewf_ram.sv -----
`default_nettype none

module pewf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- src/pewf_front.sv -----
`default_nettype none

module pewf_front import pewf_pkg::*; #(
  parameter int NUM_IDS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CNT_W-1:0]  in_face_count,
  input  wire logic [ID_W-1:0]   in_face_id,
  input  wire logic              in_frame_end,
  input  wire logic [INTV_W-1:0] event_interval,
  input  wire logic              q_can_push,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  logic [INTV_W-1:0] interval_r, interval_nxt;
  logic              fire;
  logic              id_known;
  logic              decide;

  assign in_ready = q_can_push;
  assign fire     = in_valid && q_can_push;
  assign q_push   = fire;

  // Identities past the last known one, or past the vote table, count as unknown.
  assign id_known = (in_face_id <= ID_LAST_KNOWN) && (32'(in_face_id) < NUM_IDS);

  // The decision looks at the counter value before this frame end bumps it.
  assign decide = in_frame_end && (interval_r > event_interval);

  always_comb begin
    interval_nxt = interval_r;
    if (fire && in_frame_end) begin
      if (decide) begin
        interval_nxt = '0;
      end else if (interval_r != INTV_MAX) begin
        interval_nxt = interval_r + 1'b1;
      end
    end
  end

  always_comb begin
    q_cmd.decide     = decide;
    q_cmd.face_id    = id_known ? in_face_id : ID_UNKNOWN;
    q_cmd.face_count = in_face_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
    end else begin
      interval_r <= interval_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/pewf_queue.sv -----
`default_nettype none

module pewf_queue import pewf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      can_push,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  assign can_push   = (cnt_r != (AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/pewf_back.sv -----
`default_nettype none

module pewf_back import pewf_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int NUM_IDS    = 6
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    q_valid,
  input  cmd_t                                         q_cmd,
  output logic                                         q_pop,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]         weff,
  input  wire logic [THR_W+$clog2(MAX_WINDOW+1)-1:0]   low_prod,
  input  wire logic [THR_W+$clog2(MAX_WINDOW+1)-1:0]   up_prod,
  input  wire logic [THR_W-1:0]                        gain,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic                                         out_event_kind,
  output logic [ID_W-1:0]                              out_event_face,
  output logic                                         out_last
);

  localparam int OW   = $clog2(MAX_WINDOW + 1);
  localparam int PW   = $clog2(MAX_WINDOW);
  localparam int SW   = $clog2(15 * MAX_WINDOW + 1);
  localparam int PRW  = THR_W + OW;
  localparam int SUMW = SW + Q48_SHIFT;
  localparam int CW   = (SUMW > PRW) ? SUMW : PRW;
  localparam int GPW  = OW + THR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_ARGMAX,
    ST_MUL,
    ST_DECIDE
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  cmd_t          st_cmd;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [OW-1:0] votes_r [NUM_IDS];
  logic [OW-1:0] votes_nxt [NUM_IDS];
  logic          present_r, present_nxt;
  logic [ID_W-1:0] face_r, face_nxt;

  logic [ID_W-1:0] kb_c, kb_r;
  logic [OW-1:0]   kv_c, kv_r;
  logic [GPW-1:0]  prod_r;

  ev_t        slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0] buf_cnt_r, buf_cnt_nxt;
  logic       buf_free;
  logic       out_fire;

  logic               drop_apply;
  logic               do_store;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    drop_id;
  logic [CNT_W-1:0]   drop_cnt;

  logic [ID_W-1:0] best;
  logic [CW-1:0]   sum256;
  logic            below_low;
  logic            below_up;
  logic [ID_W-1:0] enter_face;
  ev_t             ev_a, ev_b;
  logic [1:0]      ev_n;

  pewf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (do_store),
    .waddr (wp_r),
    .wdata ({st_cmd.face_id, st_cmd.face_count}),
    .raddr (tail_nxt),
    .rdata (ram_rdata)
  );

  assign drop_id  = ram_rdata[ENTRY_W-1:CNT_W];
  assign drop_cnt = ram_rdata[CNT_W-1:0];
  assign st_cmd   = (state_r == ST_IDLE) ? q_cmd : cur_r;

  assign out_valid      = (buf_cnt_r != 2'd0);
  assign out_fire       = out_valid && out_ready;
  assign out_event_kind = slot0_r.kind;
  assign out_event_face = slot0_r.face;
  assign out_last       = slot0_r.last;
  assign buf_free       = (buf_cnt_r == 2'd0) || ((buf_cnt_r == 2'd1) && out_ready);

  // Known identities share one gain, so their argmax is the largest vote count.
  always_comb begin
    kb_c = ID_UNKNOWN;
    kv_c = '0;
    for (int i = 1; i < NUM_IDS; i++) begin
      if ((i <= int'(ID_LAST_KNOWN)) && (votes_r[i] > kv_c)) begin
        kv_c = votes_r[i];
        kb_c = ID_W'(i);
      end
    end
  end

  // Decision arithmetic: compare against the unknown identity's fixed weight of one.
  always_comb begin
    best       = (prod_r > (GPW'(votes_r[0]) << Q48_SHIFT)) ? kb_r : ID_UNKNOWN;
    sum256     = CW'(sum_r) << Q48_SHIFT;
    below_low  = sum256 < CW'(low_prod);
    below_up   = sum256 < CW'(up_prod);
    enter_face = below_up ? best : ID_UNKNOWN;
    ev_a       = '{kind: EV_LEFT, face: face_r, last: 1'b0};
    ev_b       = '{kind: EV_ENTERED, face: enter_face, last: 1'b1};
    if (below_low) begin
      ev_a.last = 1'b1;
      ev_n      = present_r ? 2'd1 : 2'd0;
    end else if (present_r) begin
      ev_n = 2'd2;
    end else begin
      ev_a = ev_b;
      ev_n = 2'd1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    q_pop       = 1'b0;
    drop_apply  = 1'b0;
    do_store    = 1'b0;
    present_nxt = present_r;
    face_nxt    = face_r;
    slot0_nxt   = slot0_r;
    slot1_nxt   = slot1_r;
    buf_cnt_nxt = buf_cnt_r;

    if (out_fire) begin
      slot0_nxt   = slot1_r;
      buf_cnt_nxt = buf_cnt_r - 2'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          if (occ_r >= weff) begin
            state_nxt = ST_DROP;
          end else begin
            do_store  = 1'b1;
            state_nxt = q_cmd.decide ? ST_ARGMAX : ST_IDLE;
          end
        end
      end
      ST_DROP: begin
        drop_apply = 1'b1;
        if ((occ_r - 1'b1) < weff) begin
          do_store  = 1'b1;
          state_nxt = cur_r.decide ? ST_ARGMAX : ST_IDLE;
        end
      end
      ST_ARGMAX: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if ((ev_n == 2'd0) || buf_free) begin
          state_nxt = ST_IDLE;
          if (below_low) begin
            present_nxt = 1'b0;
            face_nxt    = ID_UNKNOWN;
          end else begin
            present_nxt = 1'b1;
            face_nxt    = enter_face;
          end
          if (ev_n != 2'd0) begin
            slot0_nxt   = ev_a;
            slot1_nxt   = ev_b;
            buf_cnt_nxt = ev_n;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Ring pointers, running sum and votes.
  always_comb begin
    logic dec_v;
    logic inc_v;
    dec_v    = 1'b0;
    inc_v    = 1'b0;
    occ_nxt  = occ_r - OW'(drop_apply) + OW'(do_store);
    tail_nxt = tail_r;
    wp_nxt   = wp_r;
    if (drop_apply) begin
      tail_nxt = (tail_r == PW'(MAX_WINDOW - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_store) begin
      wp_nxt = (wp_r == PW'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
    end
    sum_nxt = sum_r - (drop_apply ? SW'(drop_cnt) : '0) + (do_store ? SW'(st_cmd.face_count) : '0);
    for (int i = 0; i < NUM_IDS; i++) begin
      dec_v        = drop_apply && (32'(drop_id) == i) && (votes_r[i] != '0);
      inc_v        = do_store && (32'(st_cmd.face_id) == i);
      votes_nxt[i] = votes_r[i] + OW'(inc_v) - OW'(dec_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      occ_r     <= '0;
      tail_r    <= '0;
      wp_r      <= '0;
      sum_r     <= '0;
      present_r <= 1'b0;
      face_r    <= ID_UNKNOWN;
      buf_cnt_r <= 2'd0;
      for (int i = 0; i < NUM_IDS; i++) begin
        votes_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      tail_r    <= tail_nxt;
      wp_r      <= wp_nxt;
      sum_r     <= sum_nxt;
      present_r <= present_nxt;
      face_r    <= face_nxt;
      buf_cnt_r <= buf_cnt_nxt;
      slot0_r   <= slot0_nxt;
      slot1_r   <= slot1_nxt;
      for (int i = 0; i < NUM_IDS; i++) begin
        votes_r[i] <= votes_nxt[i];
      end
    end
  end

  // Payload registers: the argmax settles in the argmax state and its weighted vote in the multiply state.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kb_r   <= kb_c;
    kv_r   <= kv_c;
    prod_r <= GPW'(kv_r) * GPW'(gain);
  end

`include "presence_event_window_filter_assert.svh"

  `PEWF_ASSERT_ALWAYS(a_occ_bound, occ_r <= OW'(MAX_WINDOW), "ring occupancy above capacity")
  `PEWF_ASSERT_IMPLY(a_empty_sum, occ_r == '0, sum_r == '0, "count sum nonzero with empty ring")
  `PEWF_ASSERT_ALWAYS(a_buf_bound, buf_cnt_r <= 2'd2, "event buffer holds more than two items")
  `PEWF_ASSERT_NEXT(a_pair_kept, out_fire && !out_last, out_valid, "second event of a pair lost")

endmodule

`default_nettype wire

// ----- src/presence_event_window_filter.sv -----
// Presence event filter: turns detector observations into entered/left events.
// Input channel (in_*): one item per observation with face_count, face_id and
// frame_end, taken on in_valid && in_ready. Result channel (out_*): zero, one
// or two event items per observation, taken on out_valid && out_ready; out_last
// marks the final event of an observation. Configuration (cfg_*): a write of
// cfg_wdata to register cfg_index on each cycle cfg_we is high. Writes must
// come only while idle; the block itself does not enforce this. The back end
// takes one item per cycle while the window is filling and no decision runs;
// once it is full, each item first evicts the oldest entry with a ring memory
// read, and after a window shrink further entries are evicted one at a time.
// An item that runs a decision then passes argmax, multiply and compare; its
// events are registered, and a second event is shown once the first is taken.
// A four-entry command queue lets the input side keep accepting items while
// the result side is stalled; a held event pair stalls only decision items.
// Reset (synchronous, active low) empties the window and vote counts, clears
// the interval counter and presence state, and loads the default registers.
// The ring memory needs no clearing pass: only entries already written are read.
`default_nettype none

module presence_event_window_filter import pewf_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int NUM_IDS    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CNT_W-1:0]      in_face_count,
  input  wire logic [ID_W-1:0]       in_face_id,
  input  wire logic                  in_frame_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_event_kind,
  output logic [ID_W-1:0]            out_event_face,
  output logic                       out_last
);

  localparam int OW  = $clog2(MAX_WINDOW + 1);
  localparam int PRW = THR_W + OW;

  // Configuration registers.
  logic [WIN_REG_W-1:0] window_size_r;
  logic [THR_W-1:0]     lower_threshold_r;
  logic [THR_W-1:0]     upper_threshold_r;
  logic [THR_W-1:0]     known_face_gain_r;
  logic [INTV_W-1:0]    event_interval_r;

  // Derived values, refreshed every cycle; they settle after a write, well before
  // any accepted item reaches the decision step.
  logic [OW-1:0]  weff_r;
  logic [PRW-1:0] low_prod_r;
  logic [PRW-1:0] up_prod_r;

  logic q_can_push;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_head_valid;
  cmd_t q_head_cmd;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r     <= RST_WINDOW_SIZE;
      lower_threshold_r <= RST_LOWER_THRESHOLD;
      upper_threshold_r <= RST_UPPER_THRESHOLD;
      known_face_gain_r <= RST_KNOWN_FACE_GAIN;
      event_interval_r  <= RST_EVENT_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:     window_size_r     <= cfg_wdata[WIN_REG_W-1:0];
        REG_LOWER_THRESHOLD: lower_threshold_r <= cfg_wdata[THR_W-1:0];
        REG_UPPER_THRESHOLD: upper_threshold_r <= cfg_wdata[THR_W-1:0];
        REG_KNOWN_FACE_GAIN: known_face_gain_r <= cfg_wdata[THR_W-1:0];
        REG_EVENT_INTERVAL:  event_interval_r  <= cfg_wdata[INTV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The effective window is the register clamped to one at the bottom and to
  // the ring capacity at the top; it sets both retention and the mean divisor.
  // The mean test count_sum/W < T/256 runs as count_sum*256 < T*W, so the
  // threshold products are prepared here once per configuration.
  always_ff @(posedge clk) begin
    if (window_size_r == '0) begin
      weff_r <= OW'(1);
    end else if (32'(window_size_r) > MAX_WINDOW) begin
      weff_r <= OW'(MAX_WINDOW);
    end else begin
      weff_r <= OW'(window_size_r);
    end
    low_prod_r <= PRW'(lower_threshold_r) * PRW'(weff_r);
    up_prod_r  <= PRW'(upper_threshold_r) * PRW'(weff_r);
  end

  // Front: accepts observations, normalizes the identity and runs the frame
  // interval counter, tagging the items that trigger a decision.
  pewf_front #(
    .NUM_IDS (NUM_IDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_face_count  (in_face_count),
    .in_face_id     (in_face_id),
    .in_frame_end   (in_frame_end),
    .event_interval (event_interval_r),
    .q_can_push     (q_can_push),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd)
  );

  pewf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .can_push   (q_can_push),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  // Back: maintains the ring, running sum and votes, makes decisions and
  // holds up to two events for the result channel.
  pewf_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .NUM_IDS    (NUM_IDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_head_valid),
    .q_cmd          (q_head_cmd),
    .q_pop          (q_pop),
    .weff           (weff_r),
    .low_prod       (low_prod_r),
    .up_prod        (up_prod_r),
    .gain           (known_face_gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_face (out_event_face),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ----- verif/presence_event_window_filter_checker.sv -----
module presence_event_window_filter_checker import pewf_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int NUM_IDS    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [CNT_W-1:0]      in_face_count,
  input  wire logic [ID_W-1:0]       in_face_id,
  input  wire logic                  in_frame_end,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  out_event_kind,
  input  wire logic [ID_W-1:0]       out_event_face,
  input  wire logic                  out_last,
  output int unsigned                mismatch_count,
  output int unsigned                events_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic [WIN_REG_W-1:0] win_reg;
  logic [THR_W-1:0]     lower_reg;
  logic [THR_W-1:0]     upper_reg;
  logic [THR_W-1:0]     gain_reg;
  logic [INTV_W-1:0]    intv_reg;

  // Window state of the filter.
  logic [ID_W-1:0]  ring_id  [MAX_WINDOW];
  logic [CNT_W-1:0] ring_cnt [MAX_WINDOW];
  int unsigned      fill;
  int unsigned      wr_pos;
  int unsigned      count_sum;
  int unsigned      votes [NUM_IDS];
  logic [INTV_W-1:0] frame_counter;
  logic             present;
  logic [ID_W-1:0]  present_face;

  ev_t         predicted_events[$];
  int unsigned mismatches;

  function automatic ev_t make_ev(input logic kind, input logic [ID_W-1:0] face);
    ev_t ev;
    ev.kind = kind;
    ev.face = face;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Adds one observation to the window and queues the events it triggers.
  task automatic absorb_observation(input logic [CNT_W-1:0] cnt, input logic [ID_W-1:0] id,
                                    input logic fe);
    int unsigned win;
    int unsigned pos;
    int unsigned best;
    int unsigned best_weight;
    int unsigned weight;
    int unsigned scaled_sum;
    logic [INTV_W-1:0] old_count;
    logic [ID_W-1:0] ident;
    ev_t batch[$];

    win = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
    ident = (id > ID_LAST_KNOWN || id >= NUM_IDS) ? ID_UNKNOWN : id;

    // Evict until there is room; after a shrink this drops several entries.
    while (fill >= win) begin
      pos = (wr_pos + MAX_WINDOW - fill) % MAX_WINDOW;
      count_sum -= ring_cnt[pos];
      if (votes[ring_id[pos]] > 0) votes[ring_id[pos]]--;
      fill--;
    end
    ring_id[wr_pos]  = ident;
    ring_cnt[wr_pos] = cnt;
    wr_pos = (wr_pos + 1) % MAX_WINDOW;
    fill++;
    count_sum += cnt;
    votes[ident]++;

    if (!fe) return;
    old_count = frame_counter;
    if (frame_counter != INTV_MAX) frame_counter++;
    if (old_count <= intv_reg) return;
    frame_counter = '0;

    best = 0;
    best_weight = votes[0] << Q48_SHIFT;
    for (int i = 1; i < NUM_IDS; i++) begin
      weight = votes[i] * gain_reg;
      if (weight > best_weight) begin
        best_weight = weight;
        best = i;
      end
    end
    scaled_sum = count_sum << Q48_SHIFT;

    if (present) batch.push_back(make_ev(EV_LEFT, present_face));
    if (scaled_sum < lower_reg * win) begin
      present = 1'b0;
      present_face = ID_UNKNOWN;
    end else if (scaled_sum < upper_reg * win) begin
      batch.push_back(make_ev(EV_ENTERED, best[ID_W-1:0]));
      present = 1'b1;
      present_face = best[ID_W-1:0];
    end else begin
      batch.push_back(make_ev(EV_ENTERED, ID_UNKNOWN));
      present = 1'b1;
      present_face = ID_UNKNOWN;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) predicted_events.push_back(batch[k]);
  endtask

  always @(posedge clk) begin
    ev_t want;
    if (!rst_n) begin
      win_reg   = RST_WINDOW_SIZE;
      lower_reg = RST_LOWER_THRESHOLD;
      upper_reg = RST_UPPER_THRESHOLD;
      gain_reg  = RST_KNOWN_FACE_GAIN;
      intv_reg  = RST_EVENT_INTERVAL;
      fill = 0;
      wr_pos = 0;
      count_sum = 0;
      foreach (votes[i]) votes[i] = 0;
      frame_counter = '0;
      present = 1'b0;
      present_face = ID_UNKNOWN;
      predicted_events.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE:     win_reg   = cfg_wdata[WIN_REG_W-1:0];
          REG_LOWER_THRESHOLD: lower_reg = cfg_wdata[THR_W-1:0];
          REG_UPPER_THRESHOLD: upper_reg = cfg_wdata[THR_W-1:0];
          REG_KNOWN_FACE_GAIN: gain_reg  = cfg_wdata[THR_W-1:0];
          REG_EVENT_INTERVAL:  intv_reg  = cfg_wdata[INTV_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (predicted_events.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected event item: expected none, actual kind %0d face %0d last %0d",
                   $time, out_event_kind, out_event_face, out_last);
        end else begin
          want = predicted_events.pop_front();
          if (out_event_kind !== want.kind) begin
            mismatches++;
            $display("%0t ns: event_kind expected %0d actual %0d", $time, want.kind,
                     out_event_kind);
          end
          if (out_event_face !== want.face) begin
            mismatches++;
            $display("%0t ns: event_face expected %0d actual %0d", $time, want.face,
                     out_event_face);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $display("%0t ns: last expected %0d actual %0d", $time, want.last, out_last);
          end
        end
      end
      if (in_valid && in_ready) absorb_observation(in_face_count, in_face_id, in_frame_end);
    end
    mismatch_count <= mismatches;
    events_due     <= predicted_events.size();
  end

endmodule

// ----- verif/tb_presence_event_window_filter.sv -----
module tb_presence_event_window_filter;
  import pewf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed for observations still inside the block to drain after the
  // last predicted event has arrived. After a window shrink the first of four queued
  // items may evict all 32 entries; each may then run a decision, so this is generous.
  localparam int unsigned SETTLE_CYCLES = 200;
  // The watchdog fires after this many cycles without any handshake on either
  // channel. The longest legal quiet stretch is the long receiver hold-off.
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned SAT_ITEMS     = 260;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [CNT_W-1:0]      in_face_count;
  logic [ID_W-1:0]       in_face_id;
  logic                  in_frame_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_event_kind;
  logic [ID_W-1:0]       out_event_face;
  logic                  out_last;

  int unsigned mismatch_count;
  int unsigned events_due;
  int unsigned quiet_cycles;

  // Set once by the stimulus to ask the receiver for its long hold-off.
  bit squeeze_req = 1'b0;

  presence_event_window_filter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_face_count  (in_face_count),
    .in_face_id     (in_face_id),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_face (out_event_face),
    .out_last       (out_last)
  );

  // The checker watches every channel, predicts events and counts mismatches.
  presence_event_window_filter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_face_count  (in_face_count),
    .in_face_id     (in_face_id),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_face (out_event_face),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .events_due     (events_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random idle length: mostly none or short, now and then a long pause.
  // A busy stretch never idles at all.
  function automatic int unsigned pick_gap(input bit busy);
    int unsigned r;
    if (busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One register write per clock edge; the caller lowers cfg_we afterwards so
  // that back-to-back writes never drop and raise the enable in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [WIN_REG_W-1:0] win, input logic [THR_W-1:0] lower,
                              input logic [THR_W-1:0] upper, input logic [THR_W-1:0] gain,
                              input logic [INTV_W-1:0] interval);
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
    write_reg(REG_LOWER_THRESHOLD, lower);
    write_reg(REG_UPPER_THRESHOLD, upper);
    write_reg(REG_KNOWN_FACE_GAIN, gain);
    write_reg(REG_EVENT_INTERVAL, CFG_DATA_W'(interval));
    cfg_we <= 1'b0;
  endtask

  // Offers one observation and holds it until the block takes it. The valid
  // stays high into the next item when no gap follows.
  task automatic send_obs(input logic [CNT_W-1:0] cnt, input logic [ID_W-1:0] id,
                          input logic fe, input int unsigned gap);
    in_valid      <= 1'b1;
    in_face_count <= cnt;
    in_face_id    <= id;
    in_frame_end  <= fe;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Brings the block to idle: every predicted event has been taken and any
  // observation that causes no event has had time to leave the pipeline.
  // The first edge lets the checker's count catch up with the last item.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random configuration with the extremes of each register well represented.
  task automatic program_random(input bit force_fast, input logic [INTV_W-1:0] interval);
    logic [WIN_REG_W-1:0] win;
    logic [THR_W-1:0]     lower;
    logic [THR_W-1:0]     upper;
    logic [THR_W-1:0]     gain;
    logic [INTV_W-1:0]    intv;
    int unsigned          span;
    case ($urandom_range(0, 5))
      0: win = 6'd0;
      1: win = 6'd1;
      2: win = 6'd63;
      3: win = 6'd32;
      default: win = $urandom_range(2, 16);
    endcase
    case ($urandom_range(0, 5))
      0: lower = '0;
      1: lower = '1;
      default: lower = $urandom_range(0, 2500);
    endcase
    case ($urandom_range(0, 5))
      0: upper = '0;
      1: upper = '1;
      default: begin
        span = lower + $urandom_range(100, 2500);
        upper = (span > 4095) ? '1 : span[THR_W-1:0];
      end
    endcase
    case ($urandom_range(0, 4))
      0: gain = '0;
      1: gain = '1;
      2: gain = 12'd256;
      default: gain = $urandom_range(0, 1024);
    endcase
    intv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3);
    if (force_fast) intv = '0;
    if (interval != '0) intv = interval;
    program_regs(win, lower, upper, gain, intv);
  endtask

  // Sends a run of observations around a chosen face count level and a
  // dominant identity, so that window means settle and decisions vary.
  task automatic send_run(input int unsigned items, input int unsigned fe_pct, input bit busy);
    int unsigned level;
    int          v;
    logic [ID_W-1:0]  lead_id;
    logic [CNT_W-1:0] cnt;
    logic [ID_W-1:0]  id;
    logic             fe;
    level   = $urandom_range(0, 15);
    lead_id = $urandom_range(0, 7);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        cnt = $urandom_range(0, 15);
      end else begin
        v = int'(level) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 15) v = 15;
        cnt = v[CNT_W-1:0];
      end
      id = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : lead_id;
      fe = ($urandom_range(1, 100) <= fe_pct);
      send_obs(cnt, id, fe, pick_gap(busy));
    end
  endtask

  // Receiver: bursts of readiness broken by stalls of random length, the odd
  // long stretch with no stall, and one long hold-off on request so that the
  // command queue fills and the input side backs up.
  initial begin
    int unsigned gap;
    bit          squeezed;
    squeezed = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 15) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = pick_gap(1'b0);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: counts cycles without a handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: watchdog, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_WINDOW_SIZE;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_face_count <= '0;
    in_face_id    <= ID_UNKNOWN;
    in_frame_end  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window size zero acts as one, so every decision sees only the newest
    // item: full counts land between the thresholds, zero counts below the
    // lower one. Zero gain lets identity 0 win every tie, and ids 6 and 7
    // must be folded into the unknown identity.
    program_regs(6'd0, 12'd1, 12'hFFF, 12'd0, 8'd0);
    send_obs(4'd15, 3'd7, 1'b1, pick_gap(1'b0));
    send_obs(4'd0,  3'd6, 1'b1, pick_gap(1'b0));
    send_obs(4'd15, 3'd1, 1'b1, pick_gap(1'b0));
    send_obs(4'd15, 3'd5, 1'b0, pick_gap(1'b0));
    send_obs(4'd15, 3'd5, 1'b1, pick_gap(1'b0));
    send_obs(4'd8,  3'd3, 1'b1, pick_gap(1'b0));
    settle();

    // Window size above the maximum clamps to the maximum. Both thresholds
    // at zero put every mean at or above the upper one: entered unknown,
    // then left followed by entered. Maximum gain on the known identities.
    program_regs(6'd63, 12'd0, 12'd0, 12'hFFF, 8'd0);
    send_obs(4'd1,  3'd1, 1'b1, pick_gap(1'b0));
    send_obs(4'd2,  3'd2, 1'b1, pick_gap(1'b0));
    send_obs(4'd3,  3'd3, 1'b1, pick_gap(1'b0));
    send_obs(4'd4,  3'd4, 1'b1, pick_gap(1'b0));
    send_obs(4'd5,  3'd5, 1'b1, pick_gap(1'b0));
    send_obs(4'd0,  3'd0, 1'b1, pick_gap(1'b0));
    send_obs(4'd15, 3'd7, 1'b1, pick_gap(1'b0));
    settle();

    // Shrinking the window from the ring capacity to two drops the oldest
    // entries on the next item. Inverted thresholds leave only the lower
    // and upper cases; with the lower at maximum every mean is below it.
    program_regs(6'd2, 12'hFFF, 12'd0, 12'd256, 8'd1);
    send_obs(4'd15, 3'd2, 1'b1, pick_gap(1'b0));
    send_obs(4'd15, 3'd2, 1'b1, pick_gap(1'b0));
    send_obs(4'd0,  3'd0, 1'b1, pick_gap(1'b0));
    send_obs(4'd7,  3'd6, 1'b0, pick_gap(1'b0));
    send_obs(4'd9,  3'd4, 1'b1, pick_gap(1'b0));
    send_obs(4'd15, 3'd3, 1'b1, pick_gap(1'b0));
    settle();

    // Random phases, each under a fresh configuration. The first one runs a
    // decision on every other frame end with no sender gaps, and asks the
    // receiver for its long hold-off while the sender keeps pushing.
    for (int ph = 0; ph < 6; ph++) begin
      program_random(ph == 0, '0);
      if (ph == 0) begin
        squeeze_req = 1'b1;
        send_run(PHASE_ITEMS, 100, 1'b1);
      end else begin
        send_run(PHASE_ITEMS, $urandom_range(30, 100), $urandom_range(0, 3) == 0);
      end
      settle();
    end

    // With the interval at its maximum no decision runs and the frame counter
    // saturates. Lowering the interval afterwards must then trigger a
    // decision on the very first frame end, since the counter is not cleared.
    program_random(1'b0, INTV_MAX);
    send_run(SAT_ITEMS, 100, 1'b0);
    settle();
    program_random(1'b0, 8'd5);
    send_run(60, 80, 1'b0);

    // Wait for the last events and for the pipeline to empty, so that a
    // spurious trailing event is still caught by the checker.
    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
